// ----- rtl/lphs_pkg.sv -----
// ----------------------------------------------------------------------------
// lphs_pkg
// Types and constants for the linear-probing hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int KEY_W   = 31;
    localparam int LIMIT_W = 5;

    // Probe limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd5;

    // Hash multiplier and product width (key times multiplier)
    localparam int MULT_W = 10;
    localparam logic [MULT_W-1:0] HASH_MULT = 10'd997;
    localparam int PROD_W = KEY_W + MULT_W;

    // Serial modulo reduction: DIGIT_W product bits folded in per cycle
    localparam int DIGIT_W    = 4;
    localparam int HASH_STEPS = (PROD_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W      = HASH_STEPS * DIGIT_W;
    localparam int HSTEP_W    = $clog2(HASH_STEPS);

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // Slot status
    typedef enum logic [1:0] {
        ST_NEVER = 2'd0,
        ST_HELD  = 2'd1,
        ST_GONE  = 2'd2
    } slot_status_t;

    // One table entry
    typedef struct packed {
        slot_status_t     st;
        logic [KEY_W-1:0] key;
    } slot_t;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

endpackage

// ----- rtl/linear_probe_hash_set_top.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_set_top
// Open-addressed hash set of 31-bit keys with linear probing.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   in      | in_valid / in_ready   | kind (0 insert, 1 find, 2 remove), key
//   out     | out_valid / out_ready | ok
//   cfg     | cfg_we (no wait)      | cfg_wdata = probe_limit
//
// After reset the table is swept to never-used, one slot a cycle, over all
// TABLE_SIZE slots; in_ready stays low during the sweep.
// An item is hashed, then examines p slots (up to probe_limit), then its
// result is registered; a table size that is not a power of two adds the
// 4-bit-per-cycle modulo reduction to the hashing step.
// The probe loop runs through the single table read port, one slot a cycle.
// in_ready is high only while idle; a result waits in the output register.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_top
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [KEY_W-1:0]   key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok
);

    localparam int IDX_W   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int REM_W   = IDX_W + 1;
    localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [REM_W-1:0] SIZE_C   = REM_W'(TABLE_SIZE);
    localparam logic [HSTEP_W-1:0] LAST_HSTEP = HSTEP_W'(HASH_STEPS - 1);

    // Table storage
    slot_t mem [TABLE_SIZE];

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [LIMIT_W-1:0]   n_reg, n_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [IDX_W-1:0]     rem_reg, rem_next;
    logic [HSTEP_W-1:0]   hstep_reg, hstep_next;
    logic [PAD_W-1:0]     prod_reg, prod_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 res_ok_reg, res_ok_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 ok_reg, ok_next;
    slot_t                rd_data_reg;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    slot_t                wr_data;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     rem_step;
    logic [IDX_W-1:0]     idx_inc;

    // Fold DIGIT_W product bits into the running remainder
    always_comb
    begin
        logic [IDX_W-1:0] t;
        logic [REM_W-1:0] v;
        t = rem_reg;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            v = {t, prod_reg[PAD_W-1-i]};
            if (v >= SIZE_C)
            begin
                v = v - SIZE_C;
            end
            t = v[IDX_W-1:0];
        end
        rem_step = t;
    end

    // Next slot with wraparound
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        logic [IDX_W-1:0] home;
        logic             last;
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        hstep_next     = hstep_reg;
        prod_next      = prod_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = '0;
        rd_addr        = idx_reg;
        in_ready       = 1'b0;
        home           = IS_POW2 ? prod_reg[IDX_W-1:0] : rem_step;
        last           = (n_reg + LIMIT_W'(1)) == limit_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '{st: ST_NEVER, key: '0};
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next  = kind;
                    key_next   = key;
                    prod_next  = PAD_W'(PROD_W'(key) * PROD_W'(HASH_MULT));
                    rem_next   = '0;
                    hstep_next = '0;
                    state_next = S_HASH;
                end
            end

            S_HASH:
            begin
                if (IS_POW2 || hstep_reg == LAST_HSTEP)
                begin
                    // Home slot known: issue the first read
                    rd_addr  = home;
                    idx_next = home;
                    n_next   = '0;
                    if (limit_reg == '0 || !(kind_reg inside
                        {KIND_INSERT, KIND_FIND, KIND_REMOVE}))
                    begin
                        res_ok_next = 1'b0;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
                else
                begin
                    rem_next   = rem_step;
                    prod_next  = prod_reg << DIGIT_W;
                    hstep_next = hstep_reg + 1'b1;
                end
            end

            S_PROBE:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    if (rd_data_reg.st != ST_HELD)
                    begin
                        wr_en       = 1'b1;
                        wr_data     = '{st: ST_HELD, key: key_reg};
                        res_ok_next = 1'b1;
                        state_next  = S_RESP;
                    end
                    else if (last)
                    begin
                        res_ok_next = 1'b0;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        rd_addr  = idx_inc;
                        idx_next = idx_inc;
                        n_next   = n_reg + 1'b1;
                    end
                end
                else
                begin
                    if (rd_data_reg.st == ST_NEVER)
                    begin
                        res_ok_next = 1'b0;
                        state_next  = S_RESP;
                    end
                    else if (rd_data_reg.st == ST_HELD && rd_data_reg.key == key_reg)
                    begin
                        // Mark removed on a remove hit
                        if (kind_reg == KIND_REMOVE)
                        begin
                            wr_en   = 1'b1;
                            wr_data = '{st: ST_GONE, key: rd_data_reg.key};
                        end
                        res_ok_next = 1'b1;
                        state_next  = S_RESP;
                    end
                    else if (last)
                    begin
                        res_ok_next = 1'b0;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        rd_addr  = idx_inc;
                        idx_next = idx_inc;
                        n_next   = n_reg + 1'b1;
                    end
                end
            end

            S_RESP:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            n_reg         <= '0;
            hstep_reg     <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            hstep_reg     <= hstep_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        prod_reg   <= prod_next;
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        res_ok_reg <= res_ok_next;
        ok_reg     <= ok_next;
    end

    // Table write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Table read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;

`ifndef ASSERT_OFF
    // Probe count stays under the limit
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> n_reg < limit_reg)
        else $error("probe count reached the limit");

    // No item taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ready)
        else $error("item accepted during clear");

    // Table written only while clearing or probing
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_CLEAR || state_reg == S_PROBE))
        else $error("table write outside clear or probe");

    // Accepted item moves to hashing
    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_HASH)
        else $error("accepted item did not start hashing");
`endif

endmodule
